FILE: hdl/modular_vector_elementwise_alu_core_macros.svh
// Assertion macros for the modular vector element-wise ALU core.
`ifndef MODULAR_VECTOR_ELEMENTWISE_ALU_CORE_MACROS_SVH
`define MODULAR_VECTOR_ELEMENTWISE_ALU_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define MVEA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvea: same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define MVEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvea: next-cycle check failed");

`else

`define MVEA_ASSERT_IMPLY(label, ante, cons)

`define MVEA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/mvea_pkg.sv
// Shared constants and types for the modular vector element-wise ALU core.
`default_nettype none

package mvea_pkg;

    localparam int FIELD_BITS    = 62;
    localparam int RESIDUE_BITS  = 62;
    localparam int KIND_BITS     = 3;
    localparam int RECIP_BITS    = 64;
    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 4;
    // Registers sit at 8-byte strides, so this address bit selects the register.
    localparam int REG_SEL_BIT   = 3;
    // Two pipeline stages per multiplier bit: one doubling, one conditional add.
    localparam int MUL_STAGES    = 2 * RESIDUE_BITS;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_COPY = 3'd0,
        KIND_ADD  = 3'd1,
        KIND_SUB  = 3'd2,
        KIND_NEG  = 3'd3,
        KIND_MUL  = 3'd4,
        KIND_LOAD = 3'd5
    } kind_t;

    typedef enum logic {
        REG_MODULUS    = 1'b0,
        REG_RECIPROCAL = 1'b1
    } reg_index_t;

endpackage

`default_nettype wire

FILE: hdl/mvea_if.sv
// Valid/ready channel interfaces for operand and result transactions.
`default_nettype none

interface mvea_op_if;
    logic                                valid;
    logic                                ready;
    logic [mvea_pkg::KIND_BITS-1:0]      kind;
    logic [mvea_pkg::FIELD_BITS-1:0]     x_operand;
    logic [mvea_pkg::FIELD_BITS-1:0]     y_operand;
    logic                                last_in;

    modport source (output valid, output kind, output x_operand, output y_operand,
                    output last_in, input ready);
    modport sink   (input valid, input kind, input x_operand, input y_operand,
                    input last_in, output ready);
endinterface

interface mvea_res_if;
    logic                                valid;
    logic                                ready;
    logic [mvea_pkg::FIELD_BITS-1:0]     result;
    logic                                operand_out_of_range;
    logic                                last_out;

    modport source (output valid, output result, output operand_out_of_range,
                    output last_out, input ready);
    modport sink   (input valid, input result, input operand_out_of_range,
                    input last_out, output ready);
endinterface

`default_nettype wire

FILE: hdl/modular_vector_elementwise_alu_core.sv
// Top level of the modular vector element-wise ALU core.
//
// Usage: operand_ch carries one element per transaction (kind, x_operand, y_operand,
// last_in); result_ch returns one transaction per element (result, operand_out_of_range,
// last_out) in the same order. Both channels use valid/ready; a transaction moves on a
// rising edge with valid and ready high. The APB port holds the modulus (address 0)
// and the stored reciprocal (address 8); write them only while no element is in flight.
// An accepted element passes one entry stage, 62 stages of shift-subtract operand reduction (one
// bit each, x and y in parallel), one stage for copy/add/subtract/negate/load, 124 stages
// of shift-add modular multiply (doubling and conditional add alternate), and the output
// register. Throughput is one element per cycle while the skid register is empty, set by
// the fully pipelined reduction and multiply chains.
// A two-entry output buffer (output register plus skid register) lets one more element
// leave the pipeline while a result waits; when both are full the whole pipeline holds
// and operand_ch.ready drops until the receiver takes a result. Nothing is lost or
// repeated across a stall. Reset clears all valid bits and sets modulus 2, reciprocal 0.
`default_nettype none

`include "modular_vector_elementwise_alu_core_macros.svh"

module modular_vector_elementwise_alu_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    mvea_op_if.sink                               operand_ch,
    mvea_res_if.source                            result_ch,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mvea_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [mvea_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [mvea_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int W  = mvea_pkg::RESIDUE_BITS;
    localparam int FB = mvea_pkg::FIELD_BITS;
    localparam int MS = mvea_pkg::MUL_STAGES;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FB-1:0]                      modulus_reg;
    logic [mvea_pkg::RECIP_BITS-1:0]    recip_reg;
    logic [W-1:0]                       eff_mod_reg;
    logic [W-1:0]                       eff_mod_next;
    logic                               cfg_write;
    mvea_pkg::reg_index_t               cfg_sel;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = mvea_pkg::reg_index_t'(paddr[mvea_pkg::REG_SEL_BIT]);
    assign pready    = 1'b1;

    // A modulus below two behaves as two.
    assign eff_mod_next = (pwdata[W-1:0] < W'(2)) ? W'(2) : pwdata[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= FB'(2);
            recip_reg   <= '0;
            eff_mod_reg <= W'(2);
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                mvea_pkg::REG_MODULUS:
                begin
                    modulus_reg <= pwdata[FB-1:0];
                    eff_mod_reg <= eff_mod_next;
                end
                mvea_pkg::REG_RECIPROCAL:
                begin
                    recip_reg <= pwdata;
                end
                default:
                begin
                    recip_reg <= recip_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            mvea_pkg::REG_MODULUS:    prdata = mvea_pkg::APB_DATA_BITS'(modulus_reg);
            mvea_pkg::REG_RECIPROCAL: prdata = mvea_pkg::APB_DATA_BITS'(recip_reg);
            default:                  prdata = '0;
        endcase
    end

    logic [W:0] p_ext;
    assign p_ext = {1'b0, eff_mod_reg};

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic skid_valid_reg;
    logic pipe_en;

    assign pipe_en          = !skid_valid_reg;
    assign operand_ch.ready = pipe_en;

    // ------------------------------------------------------------------
    // Entry and operand reduction stages
    // ------------------------------------------------------------------
    logic                   red_v_reg    [0:W];
    logic [W-1:0]           red_x_reg    [0:W];
    logic [W-1:0]           red_y_reg    [0:W];
    logic [W-1:0]           red_xr_reg   [0:W];
    logic [W-1:0]           red_yr_reg   [0:W];
    mvea_pkg::kind_t        red_kind_reg [0:W];
    logic                   red_xbad_reg [0:W];
    logic                   red_ybad_reg [0:W];
    logic                   red_last_reg [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_v_reg[0] <= 1'b0;
        end
        else if (pipe_en)
        begin
            red_v_reg[0] <= operand_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            red_x_reg[0]    <= operand_ch.x_operand[W-1:0];
            red_y_reg[0]    <= operand_ch.y_operand[W-1:0];
            red_xr_reg[0]   <= '0;
            red_yr_reg[0]   <= '0;
            red_kind_reg[0] <= mvea_pkg::kind_t'(operand_ch.kind);
            red_xbad_reg[0] <= operand_ch.x_operand[W-1:0] >= eff_mod_reg;
            red_ybad_reg[0] <= operand_ch.y_operand[W-1:0] >= eff_mod_reg;
            red_last_reg[0] <= operand_ch.last_in;
        end
    end

    // Each stage shifts one operand bit into the partial remainder and subtracts
    // the modulus once; after all bits the remainder is the operand modulo p.
    for (genvar k = 0; k < W; k++)
    begin : g_red
        logic [W:0]   x_acc;
        logic [W:0]   y_acc;
        logic [W-1:0] xr_next;
        logic [W-1:0] yr_next;

        always_comb
        begin
            x_acc   = {red_xr_reg[k], red_x_reg[k][W-1]};
            y_acc   = {red_yr_reg[k], red_y_reg[k][W-1]};
            xr_next = (x_acc >= p_ext) ? W'(x_acc - p_ext) : x_acc[W-1:0];
            yr_next = (y_acc >= p_ext) ? W'(y_acc - p_ext) : y_acc[W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                red_v_reg[k+1] <= 1'b0;
            end
            else if (pipe_en)
            begin
                red_v_reg[k+1] <= red_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                red_x_reg[k+1]    <= red_x_reg[k] << 1;
                red_y_reg[k+1]    <= red_y_reg[k] << 1;
                red_xr_reg[k+1]   <= xr_next;
                red_yr_reg[k+1]   <= yr_next;
                red_kind_reg[k+1] <= red_kind_reg[k];
                red_xbad_reg[k+1] <= red_xbad_reg[k];
                red_ybad_reg[k+1] <= red_ybad_reg[k];
                red_last_reg[k+1] <= red_last_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Combinational operations on the reduced operands
    // ------------------------------------------------------------------
    logic [W-1:0]   alu_xr;
    logic [W-1:0]   alu_yr;
    logic [W:0]     alu_sum;
    logic [W-1:0]   alu_res_next;
    logic           alu_flag_next;
    logic           alu_is_mul_next;

    assign alu_xr = red_xr_reg[W];
    assign alu_yr = red_yr_reg[W];

    always_comb
    begin
        alu_sum         = {1'b0, alu_xr} + {1'b0, alu_yr};
        alu_res_next    = '0;
        alu_flag_next   = 1'b0;
        alu_is_mul_next = 1'b0;
        case (red_kind_reg[W])
            mvea_pkg::KIND_COPY:
            begin
                alu_res_next  = alu_xr;
                alu_flag_next = red_xbad_reg[W];
            end
            mvea_pkg::KIND_ADD:
            begin
                alu_res_next  = (alu_sum >= p_ext) ? W'(alu_sum - p_ext) : alu_sum[W-1:0];
                alu_flag_next = red_xbad_reg[W] || red_ybad_reg[W];
            end
            mvea_pkg::KIND_SUB:
            begin
                alu_res_next  = (alu_xr >= alu_yr) ? (alu_xr - alu_yr)
                              : W'({1'b0, alu_xr} + p_ext - {1'b0, alu_yr});
                alu_flag_next = red_xbad_reg[W] || red_ybad_reg[W];
            end
            mvea_pkg::KIND_NEG:
            begin
                alu_res_next  = (alu_xr == '0) ? '0 : (eff_mod_reg - alu_xr);
                alu_flag_next = red_xbad_reg[W];
            end
            mvea_pkg::KIND_MUL:
            begin
                // The product accumulator starts from zero.
                alu_res_next    = '0;
                alu_flag_next   = red_xbad_reg[W] || red_ybad_reg[W];
                alu_is_mul_next = 1'b1;
            end
            mvea_pkg::KIND_LOAD:
            begin
                alu_res_next  = alu_yr;
                alu_flag_next = red_ybad_reg[W];
            end
            default:
            begin
                alu_res_next  = '0;
                alu_flag_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Shift-add modular multiply stages
    // ------------------------------------------------------------------
    logic           mul_v_reg      [0:MS];
    logic [W-1:0]   mul_a_reg      [0:MS];
    logic [W-1:0]   mul_b_reg      [0:MS];
    logic [W-1:0]   mul_r_reg      [0:MS];
    logic           mul_is_mul_reg [0:MS];
    logic           mul_flag_reg   [0:MS];
    logic           mul_last_reg   [0:MS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg[0] <= 1'b0;
        end
        else if (pipe_en)
        begin
            mul_v_reg[0] <= red_v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            mul_a_reg[0]      <= alu_xr;
            mul_b_reg[0]      <= alu_yr;
            mul_r_reg[0]      <= alu_res_next;
            mul_is_mul_reg[0] <= alu_is_mul_next;
            mul_flag_reg[0]   <= alu_flag_next;
            mul_last_reg[0]   <= red_last_reg[W];
        end
    end

    // Non-multiply elements ride through with their result frozen in the accumulator.
    for (genvar j = 0; j < MS; j++)
    begin : g_mul
        logic [W:0]   acc;
        logic [W-1:0] r_next;
        logic [W-1:0] b_next;

        if ((j % 2) == 0)
        begin : g_double
            always_comb
            begin
                acc    = {mul_r_reg[j], 1'b0};
                r_next = mul_r_reg[j];
                if (mul_is_mul_reg[j])
                begin
                    r_next = (acc >= p_ext) ? W'(acc - p_ext) : acc[W-1:0];
                end
                b_next = mul_b_reg[j];
            end
        end
        else
        begin : g_add
            always_comb
            begin
                acc    = {1'b0, mul_r_reg[j]}
                       + (mul_b_reg[j][W-1] ? {1'b0, mul_a_reg[j]} : '0);
                r_next = mul_r_reg[j];
                if (mul_is_mul_reg[j])
                begin
                    r_next = (acc >= p_ext) ? W'(acc - p_ext) : acc[W-1:0];
                end
                b_next = mul_b_reg[j] << 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mul_v_reg[j+1] <= 1'b0;
            end
            else if (pipe_en)
            begin
                mul_v_reg[j+1] <= mul_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                mul_a_reg[j+1]      <= mul_a_reg[j];
                mul_b_reg[j+1]      <= b_next;
                mul_r_reg[j+1]      <= r_next;
                mul_is_mul_reg[j+1] <= mul_is_mul_reg[j];
                mul_flag_reg[j+1]   <= mul_flag_reg[j];
                mul_last_reg[j+1]   <= mul_last_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid register
    // ------------------------------------------------------------------
    logic           out_valid_next;
    logic           skid_valid_next;
    logic           out_from_skid;
    logic           out_from_pipe;
    logic           skid_from_pipe;
    logic           pipe_leaving;
    logic [W-1:0]   out_result_reg;
    logic           out_flag_reg;
    logic           out_last_reg;
    logic [W-1:0]   skid_result_reg;
    logic           skid_flag_reg;
    logic           skid_last_reg;

    assign pipe_leaving = pipe_en && mul_v_reg[MS];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_from_skid   = 1'b0;
        out_from_pipe   = 1'b0;
        skid_from_pipe  = 1'b0;
        if (skid_valid_reg)
        begin
            if (result_ch.ready)
            begin
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_leaving)
        begin
            if (!out_valid_reg || result_ch.ready)
            begin
                out_from_pipe  = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_from_pipe  = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
        begin
            out_result_reg <= skid_result_reg;
            out_flag_reg   <= skid_flag_reg;
            out_last_reg   <= skid_last_reg;
        end
        else if (out_from_pipe)
        begin
            out_result_reg <= mul_r_reg[MS];
            out_flag_reg   <= mul_flag_reg[MS];
            out_last_reg   <= mul_last_reg[MS];
        end
        if (skid_from_pipe)
        begin
            skid_result_reg <= mul_r_reg[MS];
            skid_flag_reg   <= mul_flag_reg[MS];
            skid_last_reg   <= mul_last_reg[MS];
        end
    end

    assign result_ch.valid                = out_valid_reg;
    assign result_ch.result               = FB'(out_result_reg);
    assign result_ch.operand_out_of_range = out_flag_reg;
    assign result_ch.last_out             = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MVEA_ASSERT_IMPLY(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `MVEA_ASSERT_IMPLY(a_result_reduced, out_valid_reg, out_result_reg < eff_mod_reg)
    `MVEA_ASSERT_NEXT(a_stall_fills_skid, pipe_leaving && out_valid_reg && !result_ch.ready, skid_valid_reg)

endmodule

`default_nettype wire
